/* hdl/btp_pkg.sv */
package btp_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int PIX_W        = 8;
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = (CFG_WIDTH_W > CFG_HEIGHT_W) ? CFG_WIDTH_W : CFG_HEIGHT_W;
  localparam int CFG_INDEX_W  = 1;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int EFF_W        = COL_W + 1;
  localparam int WCMP_W       = (EFF_W > CFG_WIDTH_W) ? EFF_W : CFG_WIDTH_W;
  localparam int ROW_W        = CFG_HEIGHT_W;
  localparam int PROD_W       = EFF_W + CFG_HEIGHT_W;
  localparam int LINE_W       = 2 * PIX_W;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

  localparam logic [PIX_W-1:0] FULL_PIXEL = PIX_W'(255);

  typedef logic [1:0] tcell_t;
  localparam tcell_t T0 = 2'd0;
  localparam tcell_t T1 = 2'd1;
  localparam tcell_t TX = 2'd2;

  typedef tcell_t [2:0][2:0] tmpl_t;

  localparam tmpl_t BASE_A = '{'{T1, T1, T1}, '{TX, T1, TX}, '{T0, T0, T0}};
  localparam tmpl_t BASE_B = '{'{TX, T1, TX}, '{T0, T1, T1}, '{T0, T0, TX}};

  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             removed;
    logic             frame_end;
    logic             frame_changed;
  } btp_result_t;

  function automatic logic cell_ok(tcell_t t, logic [PIX_W-1:0] v);
    logic ok;
    case (t)
      T1:      ok = (v == FULL_PIXEL);
      T0:      ok = (v == '0);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  function automatic logic tmpl_hits(win_t w, tmpl_t b, int rot);
    logic   ok;
    tcell_t t;
    ok = 1'b1;
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        case (rot)
          1:       t = b[x][2-y];
          2:       t = b[2-y][2-x];
          3:       t = b[2-x][y];
          default: t = b[y][x];
        endcase
        ok = ok & cell_ok(t, w[y][x]);
      end
    end
    return ok;
  endfunction

  function automatic logic match_any(win_t w);
    logic hit;
    hit = 1'b0;
    for (int rot = 0; rot < 4; rot++) begin
      hit = hit | tmpl_hits(w, BASE_A, rot) | tmpl_hits(w, BASE_B, rot);
    end
    return hit;
  endfunction

endpackage

/* hdl/btp_ram.sv */
module btp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/btp_fifo.sv */
module btp_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  btp_pkg::btp_result_t              data_i,
  input  logic                              pop_i,
  output btp_pkg::btp_result_t              data_o,
  output logic                              valid_o,
  output logic [btp_pkg::FIFO_CNT_W-1:0]    count_o
);

  import btp_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  btp_result_t       slot_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    head_d = pop_i  ? head_q + 1'b1 : head_q;
    tail_d = push_i ? tail_q + 1'b1 : tail_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[tail_q] <= data_i;
    end
  end

  assign data_o  = slot_q[head_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

endmodule

/* hdl/binary_thinning_pass.sv */
// One pass of 3x3 hit-or-miss thinning over a raster stream of 8-bit pixels.
//
// Input channel (in_valid_i / in_ready_o): one word per pixel in raster order,
// mode_i = 1 marks a flush word that enters as a zero pixel. Output channel
// (out_valid_o / out_ready_i): zero or one result word per input word.
// The result for the pixel at stream position k leaves with input word k+W+1
// (W = image width), through the accept-stage register and the result queue; a
// frame of W*H pixels needs W+1 trailing flush words to drain completely.
// Throughput is one word per cycle while in_ready_o is high: both line
// buffers share one 16-bit wide memory, read on accept and written back
// in the cycle after, with forwarding when the same column is read and
// written in the same cycle. A four-entry result queue decouples the
// receiver; input ready drops only when results in flight could fill it,
// so stalls on the output back up into the input without losing words.
// Reset sets width 640, height 480 and restarts the frame; line buffer
// contents are not cleared (only border windows read stale entries).
// Writing either register through cfg_we_i restarts the frame.
module binary_thinning_pass (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [btp_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [btp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic [btp_pkg::PIX_W-1:0]           pixel_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [btp_pkg::PIX_W-1:0]           out_pixel_o,
  output logic                                removed_o,
  output logic                                frame_end_o,
  output logic                                frame_changed_o
);

  import btp_pkg::*;

  logic [CFG_WIDTH_W-1:0]  width_q;
  logic [CFG_HEIGHT_W-1:0] height_q;
  logic [EFF_W-1:0]        eff_w;
  logic [CFG_HEIGHT_W-1:0] eff_h;
  logic [PROD_W-1:0]       wh_q;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [PROD_W-1:0] emitted_q, emitted_d;

  logic             acc;
  logic [PIX_W-1:0] in_pix;
  logic             emit, interior, last;
  logic [EFF_W-1:0] col_next;

  logic              s1_v_q;
  logic [COL_W-1:0]  s1_col_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic              s1_emit_q, s1_interior_q, s1_last_q;
  logic              fwd_hit_q;
  logic [LINE_W-1:0] fwd_data_q;

  logic [LINE_W-1:0] ram_rdata, line_rd, line_wr;
  logic [PIX_W-1:0]  top, mid, centre;
  win_t              win_q, win_d;
  logic              rem, any_q;

  logic                  push, pop;
  btp_result_t           res, res_out;
  logic [FIFO_CNT_W-1:0] fifo_cnt;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_WIDTH_W'(WIDTH_RESET);
      height_q <= CFG_HEIGHT_W'(HEIGHT_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = EFF_W'(1);
    end else if (WCMP_W'(width_q) > WCMP_W'(MAX_WIDTH)) begin
      eff_w = EFF_W'(MAX_WIDTH);
    end else begin
      eff_w = EFF_W'(width_q);
    end
    if (height_q == '0) begin
      eff_h = CFG_HEIGHT_W'(1);
    end else if (height_q > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
      eff_h = CFG_HEIGHT_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wh_q <= PROD_W'(WIDTH_RESET * HEIGHT_RESET);
    end else begin
      wh_q <= PROD_W'(eff_w) * PROD_W'(eff_h);
    end
  end

  // accept stage: position counters
  assign in_ready_o = (FIFO_CNT_W'(s1_v_q) + fifo_cnt) < FIFO_CNT_W'(FIFO_DEPTH);
  assign acc        = in_valid_i && in_ready_o;
  assign in_pix     = mode_i ? '0 : pixel_value_i;

  assign emit     = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
  assign interior = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2))
                    && (row_q <= ROW_W'(eff_h - 1'b1));
  assign last     = emit && ((emitted_q + 1'b1) >= wh_q);
  assign col_next = EFF_W'(col_q) + 1'b1;

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    emitted_d = emitted_q;
    if (cfg_we_i) begin
      col_d     = '0;
      row_d     = '0;
      emitted_d = '0;
    end else if (acc) begin
      if (last) begin
        col_d     = '0;
        row_d     = '0;
        emitted_d = '0;
      end else begin
        if (col_next >= eff_w) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_next[COL_W-1:0];
        end
        if (emit) begin
          emitted_d = emitted_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      emitted_q <= '0;
      s1_v_q    <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      emitted_q <= emitted_d;
      s1_v_q    <= acc;
      fwd_hit_q <= acc && s1_v_q && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_col_q      <= col_q;
      s1_pix_q      <= in_pix;
      s1_emit_q     <= emit;
      s1_interior_q <= interior;
      s1_last_q     <= last;
      fwd_data_q    <= line_wr;
    end
  end

  // line buffers: upper in the high byte, middle in the low byte
  btp_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_v_q),
    .waddr_i(s1_col_q),
    .wdata_i(line_wr),
    .re_i   (acc),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  assign line_rd = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign top     = line_rd[LINE_W-1:PIX_W];
  assign mid     = line_rd[PIX_W-1:0];
  assign line_wr = {mid, s1_pix_q};

  // window shift and template match
  always_comb begin
    win_d = win_q;
    for (int y = 0; y < 3; y++) begin
      win_d[y][0] = win_q[y][1];
      win_d[y][1] = win_q[y][2];
    end
    win_d[0][2] = top;
    win_d[1][2] = mid;
    win_d[2][2] = s1_pix_q;
  end

  assign centre = win_d[1][1];
  assign rem    = s1_interior_q && (centre != '0) && match_any(win_d);
  assign push   = s1_v_q && s1_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      any_q <= 1'b0;
    end else begin
      if (s1_v_q) begin
        win_q <= win_d;
      end
      if (cfg_we_i || (push && s1_last_q)) begin
        any_q <= 1'b0;
      end else if (push && rem) begin
        any_q <= 1'b1;
      end
    end
  end

  always_comb begin
    res.out_pixel     = rem ? '0 : centre;
    res.removed       = rem;
    res.frame_end     = s1_last_q;
    res.frame_changed = s1_last_q && (any_q || rem);
  end

  assign pop = out_valid_o && out_ready_i;

  btp_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res),
    .pop_i  (pop),
    .data_o (res_out),
    .valid_o(out_valid_o),
    .count_o(fifo_cnt)
  );

  assign out_pixel_o     = res_out.out_pixel;
  assign removed_o       = res_out.removed;
  assign frame_end_o     = res_out.frame_end;
  assign frame_changed_o = res_out.frame_changed;

  a_fifo_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
    else $error("result queue overflow");

  a_changed_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_changed_o) |-> frame_end_o)
    else $error("frame_changed without frame_end");

  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && removed_o) |-> (out_pixel_o == '0))
    else $error("removed pixel not cleared");

  a_fwd_only_on_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_v_q && $past(s1_v_q))
    else $error("forward without back-to-back words");

endmodule

/* dv/binary_thinning_pass_tb.sv */
`timescale 1ns / 1ps

module binary_thinning_pass_tb;

  localparam bit MODE_PIXEL = 1'b0;
  localparam bit MODE_FLUSH = 1'b1;

  localparam int unsigned IDLE_MAX      = 16;
  localparam int unsigned SETTLE        = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned EXTREME_WORDS = 80;
  localparam int unsigned RANDOM_WORDS  = 1350;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  // Template cell k = row * 3 + col; CARE marks cells that must match, ONES marks 255.
  localparam bit [8:0] THIN_A_CARE = 9'b111_010_111;
  localparam bit [8:0] THIN_A_ONES = 9'b111_010_000;
  localparam bit [8:0] THIN_B_CARE = 9'b010_111_110;
  localparam bit [8:0] THIN_B_ONES = 9'b010_011_000;

  localparam bit [0:15][7:0] DIR_IMAGE = {
    8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd255, 8'd255, 8'd0,
    8'd255, 8'd255, 8'd255, 8'd7,
    8'd128, 8'd255, 8'd254, 8'd255
  };
  localparam bit [0:15] DIR_FLUSH = 16'b0000_0000_0000_0100;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [btp_pkg::CFG_INDEX_W-1:0]   cfg_index_i;
  logic [btp_pkg::CFG_DATA_W-1:0]    cfg_data_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic                              mode_i;
  logic [btp_pkg::PIX_W-1:0]         pixel_value_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic [btp_pkg::PIX_W-1:0]         out_pixel_o;
  logic                              removed_o;
  logic                              frame_end_o;
  logic                              frame_changed_o;

  binary_thinning_pass u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .pixel_value_i   (pixel_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_pixel_o     (out_pixel_o),
    .removed_o       (removed_o),
    .frame_end_o     (frame_end_o),
    .frame_changed_o (frame_changed_o)
  );

  btp_pkg::btp_result_t thinned_q [$];
  btp_pkg::btp_result_t want;

  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  int unsigned words_sent   = 0;
  int unsigned tx_gap_max   = IDLE_MAX;
  int unsigned rx_stall_max = IDLE_MAX;
  int unsigned rx_hold_len  = 0;

  int unsigned  reg_width;
  int unsigned  reg_height;
  bit [7:0]     line_up  [btp_pkg::MAX_WIDTH];
  bit [7:0]     line_mid [btp_pkg::MAX_WIDTH];
  bit [7:0]     win [3][3];
  int unsigned  col_pos;
  int unsigned  row_pos;
  int unsigned  emitted;
  bit           frame_hit;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned active_width();
    if (reg_width == 0) return 1;
    if (reg_width > btp_pkg::MAX_WIDTH) return btp_pkg::MAX_WIDTH;
    return reg_width;
  endfunction

  function automatic int unsigned active_height();
    if (reg_height == 0) return 1;
    if (reg_height > btp_pkg::MAX_HEIGHT) return btp_pkg::MAX_HEIGHT;
    return reg_height;
  endfunction

  function automatic bit window_thins();
    bit       hit_any;
    bit       ok;
    bit [8:0] care;
    bit [8:0] ones;
    int       ty;
    int       tx;
    hit_any = 1'b0;
    for (int rot = 0; rot < 4; rot++) begin
      for (int b = 0; b < 2; b++) begin
        care = b ? THIN_B_CARE : THIN_A_CARE;
        ones = b ? THIN_B_ONES : THIN_A_ONES;
        ok = 1'b1;
        for (int y = 0; y < 3; y++) begin
          for (int x = 0; x < 3; x++) begin
            case (rot)
              1: begin ty = x;     tx = 2 - y; end
              2: begin ty = 2 - y; tx = 2 - x; end
              3: begin ty = 2 - x; tx = y;     end
              default: begin ty = y; tx = x; end
            endcase
            if (care[ty * 3 + tx])
              ok &= (win[y][x] == (ones[ty * 3 + tx] ? 8'hFF : 8'h00));
          end
        end
        hit_any |= ok;
      end
    end
    return hit_any;
  endfunction

  task automatic frame_restart();
    col_pos   = 0;
    row_pos   = 0;
    emitted   = 0;
    frame_hit = 1'b0;
  endtask

  task automatic thin_reset();
    reg_width  = btp_pkg::WIDTH_RESET;
    reg_height = btp_pkg::HEIGHT_RESET;
    foreach (line_up[i]) begin
      line_up[i]  = '0;
      line_mid[i] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;
    frame_restart();
  endtask

  task automatic thin_predict(input bit mode, input bit [7:0] value);
    int unsigned          w;
    int unsigned          h;
    int unsigned          ix;
    int unsigned          iy;
    bit [7:0]             p;
    bit [7:0]             top;
    bit [7:0]             mid;
    bit [7:0]             ctr;
    bit                   emit;
    bit                   hit;
    bit                   last;
    btp_pkg::btp_result_t res;
    w  = active_width();
    h  = active_height();
    ix = (col_pos >= w) ? 0 : col_pos;
    iy = row_pos;
    p  = (mode == MODE_FLUSH) ? 8'd0 : value;
    top = line_up[ix];
    mid = line_mid[ix];
    line_up[ix]  = mid;
    line_mid[ix] = p;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = p;
    emit = (iy >= 2) || (iy == 1 && ix >= 1);
    col_pos = ix + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = iy + 1;
    end
    if (emit) begin
      ctr = win[1][1];
      hit = (ix >= 2) && (iy >= 2) && (iy <= h - 1) && (ctr != 0) && window_thins();
      if (hit) frame_hit = 1'b1;
      last = (emitted + 1 >= w * h);
      res.out_pixel     = hit ? 8'd0 : ctr;
      res.removed       = hit;
      res.frame_end     = last;
      res.frame_changed = last && frame_hit;
      thinned_q.push_back(res);
      emitted++;
      if (last) frame_restart();
    end
  endtask

  function automatic bit [7:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 8'd255;
    if (r < 8) return 8'd0;
    return 8'($urandom);
  endfunction

  task automatic send_word(input bit mode, input bit [7:0] value);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    pixel_value_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    thin_predict(mode, value);
    words_sent++;
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (thinned_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic quiesce();
    wait_results();
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [btp_pkg::CFG_INDEX_W-1:0] index,
                           input logic [btp_pkg::CFG_DATA_W-1:0]  data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == btp_pkg::REG_IMAGE_WIDTH) reg_width = data[btp_pkg::CFG_WIDTH_W-1:0];
    else reg_height = data[btp_pkg::CFG_HEIGHT_W-1:0];
    frame_restart();
  endtask

  task automatic set_frame(input logic [btp_pkg::CFG_DATA_W-1:0] wd,
                           input logic [btp_pkg::CFG_DATA_W-1:0] hd);
    quiesce();
    write_reg(btp_pkg::REG_IMAGE_WIDTH, wd);
    write_reg(btp_pkg::REG_IMAGE_HEIGHT, hd);
  endtask

  task automatic send_frame(input int unsigned noise_pct, input bit broken);
    int unsigned w;
    int unsigned pix;
    int unsigned total;
    int unsigned stop_at;
    w       = active_width();
    pix     = w * active_height();
    total   = pix + w + 1;
    stop_at = broken ? $urandom_range(1, total - 1) : total;
    for (int unsigned k = 0; k < stop_at; k++) begin
      if (k < pix) begin
        if ($urandom_range(0, 99) < noise_pct) send_word(MODE_FLUSH, 8'($urandom));
        else send_word(MODE_PIXEL, pick_pixel());
      end else if ($urandom_range(0, 99) < noise_pct) begin
        send_word(MODE_PIXEL, 8'($urandom));
      end else begin
        send_word(MODE_FLUSH, 8'($urandom));
      end
    end
  endtask

  task automatic send_noise(input int unsigned count);
    repeat (count)
      send_word(($urandom_range(0, 3) == 0) ? MODE_FLUSH : MODE_PIXEL, pick_pixel());
  endtask

  task automatic test_directed();
    set_frame(13'h1004, 13'd4);
    for (int k = 0; k < 16; k++)
      send_word(DIR_FLUSH[k] ? MODE_FLUSH : MODE_PIXEL, DIR_IMAGE[k]);
    send_word(MODE_FLUSH, 8'd0);
    send_word(MODE_PIXEL, 8'hAA);
    send_word(MODE_FLUSH, 8'hFF);
    repeat (2) send_word(MODE_FLUSH, 8'd0);
    set_frame(13'd0, 13'd0);
    send_word(MODE_PIXEL, 8'd200);
    repeat (2) send_word(MODE_FLUSH, 8'd0);
  endtask

  task automatic test_register_extremes();
    set_frame(13'h0FFF, 13'd1);
    send_noise(EXTREME_WORDS);
    set_frame(13'd1, 13'h1FFF);
    send_noise(EXTREME_WORDS);
    set_frame(13'd2048, 13'd4096);
    send_noise(EXTREME_WORDS);
  endtask

  task automatic test_backpressure();
    set_frame(13'd6, 13'd5);
    tx_gap_max  = 0;
    rx_hold_len = HOLD_CYCLES;
    repeat (2) send_frame(0, 1'b0);
    tx_gap_max = IDLE_MAX;
    for (int k = 0; k < 37; k++) begin
      if (k == 17) wait_results();
      send_word((k < 30) ? MODE_PIXEL : MODE_FLUSH, pick_pixel());
    end
  endtask

  task automatic test_random_frames();
    int unsigned                    start;
    int unsigned                    pick;
    logic [btp_pkg::CFG_DATA_W-1:0] wd;
    logic [btp_pkg::CFG_DATA_W-1:0] hd;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        wd = ($urandom_range(0, 1) == 0) ? 13'd2048 : 13'($urandom_range(2049, 8191));
        hd = 13'($urandom);
        set_frame(wd, hd);
        tx_gap_max   = IDLE_MAX;
        rx_stall_max = IDLE_MAX;
        send_noise($urandom_range(20, 150));
      end else begin
        wd = (pick == 1) ? 13'($urandom_range(0, 1)) : 13'($urandom_range(2, 9));
        wd[btp_pkg::CFG_DATA_W-1] = 1'($urandom_range(0, 1));
        hd = (pick == 1) ? 13'($urandom_range(0, 8)) : 13'($urandom_range(1, 6));
        set_frame(wd, hd);
        tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
        rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
        repeat ($urandom_range(1, 4))
          send_frame(($urandom_range(0, 3) == 0) ? 10 : 0, $urandom_range(0, 4) == 0);
      end
    end
    tx_gap_max   = IDLE_MAX;
    rx_stall_max = IDLE_MAX;
  endtask

  initial begin : receiver
    int unsigned n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_len != 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        n = $urandom_range(0, rx_stall_max);
      end
      if (n != 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("binary_thinning_pass_tb NOT OK");
      $finish;
    end else if (rst_ni && out_valid_o && out_ready_i) begin
      if (thinned_q.size() == 0) begin
        errors++;
        $error("result word with no pending pixel: out_pixel %0d removed %0b",
               out_pixel_o, removed_o);
      end else begin
        want = thinned_q.pop_front();
        if (out_pixel_o !== want.out_pixel) begin
          errors++;
          $error("out_pixel: expected %0d, got %0d", want.out_pixel, out_pixel_o);
        end
        if (removed_o !== want.removed) begin
          errors++;
          $error("removed: expected %0b, got %0b", want.removed, removed_o);
        end
        if (frame_end_o !== want.frame_end) begin
          errors++;
          $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end_o);
        end
        if (frame_changed_o !== want.frame_changed) begin
          errors++;
          $error("frame_changed: expected %0b, got %0b", want.frame_changed,
                 frame_changed_o);
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_PIXEL;
    pixel_value_i = '0;
    thin_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_frames();
    quiesce();
    if (errors == 0) $display("binary_thinning_pass_tb OK");
    else $display("binary_thinning_pass_tb NOT OK");
    $finish;
  end

endmodule
